// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PABB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pabb assertion failed");

// Next-cycle implication.
`define PABB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pabb assertion failed");

`endif

// ===== rtl/pabb_pkg.sv =====
// Package for the page-aligned bitmap blit: types, register indexes,
// command constants and default geometry. No dependencies.
package pabb_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;

  localparam int DATA_W     = 8;
  localparam int PAGE_W     = 4;   // up to 16 pages of 8 rows
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int BITS_PER_PAGE = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_PX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH = 3'd4;

  localparam logic [DATA_W-1:0] CMD_COL_LO_MASK = 8'h0F;
  localparam logic [DATA_W-1:0] CMD_COL_HI_BASE = 8'h10;
  localparam logic [DATA_W-1:0] CMD_PAGE_BASE   = 8'hB0;

  typedef struct packed {
    logic [6:0] origin_x;
    logic [5:0] origin_y;
    logic [7:0] width_px;
    logic [6:0] height_px;
    logic       pass_through;
  } pabb_cfg_t;

  // One accepted image byte with its position decisions.
  typedef struct packed {
    logic [DATA_W-1:0] cur;
    logic [PAGE_W-1:0] page;
    logic              cmds;      // column 0: cursor commands go first
    logic              is_first;  // first image page, no carry
    logic              tail;      // spill page built from the line store only
    logic              last;
  } pabb_item_t;

  typedef enum logic [1:0] {
    PH_COL_LO,
    PH_COL_HI,
    PH_PAGE,
    PH_DATA
  } pabb_phase_t;

endpackage

// ===== rtl/pabb_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module pabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pabb_pos.sv =====
// Position tracker: geometry check, page/column state, line store access.
// Depends on pabb_pkg.
module pabb_pos #(
  parameter int DISPLAY_WIDTH  = pabb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = pabb_pkg::DISPLAY_HEIGHT_DEF,
  localparam int COL_W = $clog2(DISPLAY_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pabb_pkg::pabb_cfg_t             cfg,
  input  logic                            restart,
  input  logic [pabb_pkg::PAGE_W-1:0]     restart_page,
  input  logic                            take,
  input  logic [pabb_pkg::DATA_W-1:0]     image_byte,
  output logic                            item_load,
  output pabb_pkg::pabb_item_t            item,
  output logic                            ram_we,
  output logic                            ram_re,
  output logic [COL_W-1:0]                ram_addr,
  output logic [pabb_pkg::DATA_W-1:0]     ram_wdata
);

  logic [pabb_pkg::PAGE_W-1:0] page_now, page_next;
  logic [COL_W-1:0]            column_now, column_next;

  logic                        geo_ok;
  logic [pabb_pkg::PAGE_W-1:0] first_page, final_page, page_eff, rel;
  logic [8:0]                  y_end;
  logic [5:0]                  final_page_full, image_pages;
  logic [8:0]                  pages_sum;
  logic [COL_W-1:0]            col_eff;
  logic [8:0]                  col_plus;
  logic                        pos_bad, wrap, tail;

  always_comb begin
    geo_ok = (cfg.width_px != 8'd0) && (cfg.height_px != 7'd0)
          && ((10'(cfg.origin_x) + 10'(cfg.width_px)) <= 10'(DISPLAY_WIDTH))
          && ((9'(cfg.origin_y) + 9'(cfg.height_px)) <= 9'(DISPLAY_HEIGHT));

    first_page      = pabb_pkg::PAGE_W'(cfg.origin_y[5:3]);
    y_end           = 9'(cfg.origin_y) + 9'(cfg.height_px) - 9'd1;
    final_page_full = y_end[8:3];
    final_page      = pabb_pkg::PAGE_W'(final_page_full);
    pages_sum       = 9'(cfg.height_px) + 9'd7;
    image_pages     = pages_sum[8:3];

    pos_bad = (page_now < first_page) || (6'(page_now) > final_page_full)
           || (9'(column_now) >= 9'(cfg.width_px));
    page_eff = pos_bad ? first_page : page_now;
    col_eff  = pos_bad ? '0 : column_now;

    rel  = page_eff - first_page;
    tail = 6'(rel) >= image_pages;

    col_plus = 9'(col_eff) + 9'd1;
    wrap     = col_plus >= 9'(cfg.width_px);
  end

  always_comb begin
    page_next   = page_now;
    column_next = column_now;
    if (restart) begin
      page_next   = restart_page;
      column_next = '0;
    end else if (take && geo_ok) begin
      if (wrap) begin
        column_next = '0;
        page_next   = (page_eff == final_page) ? first_page : page_eff + 1'b1;
      end else begin
        column_next = col_plus[COL_W-1:0];
        page_next   = page_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_now   <= '0;
      column_now <= '0;
    end else begin
      page_now   <= page_next;
      column_now <= column_next;
    end
  end

  assign item_load = take && geo_ok;

  always_comb begin
    item.cur      = image_byte;
    item.page     = page_eff;
    item.cmds     = (col_eff == '0);
    item.is_first = (rel == '0);
    item.tail     = tail;
    item.last     = (page_eff == final_page)
                 && (9'(col_eff) == (9'(cfg.width_px) - 9'd1));
  end

  // Read-first RAM: the read sees the byte of the page above even when
  // the same column is written at this edge.
  assign ram_re    = item_load;
  assign ram_we    = item_load && !tail;
  assign ram_addr  = col_eff;
  assign ram_wdata = image_byte;

endmodule

// ===== rtl/pabb_emit.sv =====
// Output sequencer: holds one item, sends cursor commands and the data
// beat through a registered output stage. Depends on pabb_pkg.
module pabb_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  pabb_pkg::pabb_cfg_t         cfg,
  input  logic                        item_load,
  input  pabb_pkg::pabb_item_t        item,
  input  logic [pabb_pkg::DATA_W-1:0] ram_rdata,
  input  logic                        out_stall,
  output logic                        busy,
  output logic                        out_valid,
  output logic [pabb_pkg::DATA_W-1:0] out_byte,
  output logic                        is_command,
  output logic                        last
);

  logic                  st_valid, st_valid_next;
  pabb_pkg::pabb_item_t  st_item;
  pabb_pkg::pabb_phase_t phase, phase_next;

  logic                        out_load, done;
  logic [2:0]                  offset;
  logic [pabb_pkg::DATA_W-1:0] carry, shifted, data_b, beat_byte;
  logic                        beat_cmd, beat_last;

  assign out_load = st_valid && (!out_valid || !out_stall);
  assign done     = out_load && (phase == pabb_pkg::PH_DATA);
  assign busy     = st_valid && !done;

  // next state
  always_comb begin
    phase_next = phase;
    if (item_load) begin
      phase_next = item.cmds ? pabb_pkg::PH_COL_LO : pabb_pkg::PH_DATA;
    end else if (out_load) begin
      unique case (phase)
        pabb_pkg::PH_COL_LO: phase_next = pabb_pkg::PH_COL_HI;
        pabb_pkg::PH_COL_HI: phase_next = pabb_pkg::PH_PAGE;
        pabb_pkg::PH_PAGE:   phase_next = pabb_pkg::PH_DATA;
        pabb_pkg::PH_DATA:   phase_next = pabb_pkg::PH_DATA;
      endcase
    end
    st_valid_next = item_load ? 1'b1 : (done ? 1'b0 : st_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      phase    <= pabb_pkg::PH_DATA;
    end else begin
      st_valid <= st_valid_next;
      phase    <= phase_next;
    end
    if (item_load) begin
      st_item <= item;
    end
  end

  // data byte: shift down by row offset, merge carry from page above, invert unless pass-through
  always_comb begin
    offset  = cfg.origin_y[2:0];
    carry   = (offset != 3'd0)
            ? (ram_rdata >> (4'(pabb_pkg::BITS_PER_PAGE) - 4'(offset))) : '0;
    shifted = st_item.cur << offset;
    if (st_item.is_first) begin
      data_b = shifted;
    end else if (st_item.tail) begin
      data_b = carry;
    end else begin
      data_b = carry | shifted;
    end
    if (!cfg.pass_through) begin
      data_b = ~data_b;
    end
  end

  // outputs
  always_comb begin
    beat_cmd  = 1'b1;
    beat_last = 1'b0;
    unique case (phase)
      pabb_pkg::PH_COL_LO: beat_byte = 8'(cfg.origin_x) & pabb_pkg::CMD_COL_LO_MASK;
      pabb_pkg::PH_COL_HI: beat_byte = pabb_pkg::CMD_COL_HI_BASE + 8'(cfg.origin_x[6:4]);
      pabb_pkg::PH_PAGE:   beat_byte = pabb_pkg::CMD_PAGE_BASE + 8'(st_item.page);
      pabb_pkg::PH_DATA: begin
        beat_byte = data_b;
        beat_cmd  = 1'b0;
        beat_last = st_item.last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_byte   <= beat_byte;
      is_command <= beat_cmd;
      last       <= beat_last;
    end
  end

endmodule

// ===== rtl/page_aligned_bitmap_blit_top.sv =====
// Path: an accepted byte is registered in the item stage, then its first beat in the
//   output register (first cursor command at column 0, otherwise the data beat).
// Throughput: 1 byte per cycle mid-page while out_stall is low; a byte at column 0
//   holds the item stage for 3 command beats + 1 data beat on one output port.
// Reset (rst, sync, active high): config regs 0, position at page 0 column 0,
//   pipeline empty. The line store is not cleared and needs no clearing pass.
module page_aligned_bitmap_blit_top #(
  parameter int DISPLAY_WIDTH  = pabb_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = pabb_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pabb_pkg::CFG_DATA_W-1:0] cfg_data,
  // image byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      image_byte,
  // display byte output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            is_command,
  output logic                            last
);

  localparam int COL_W = $clog2(DISPLAY_WIDTH);

  pabb_pkg::pabb_cfg_t  cfg, cfg_next;
  pabb_pkg::pabb_item_t item;

  logic                        cfg_write, take, item_load, busy;
  logic                        ram_we, ram_re;
  logic [COL_W-1:0]            ram_addr;
  logic [pabb_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  // Config is always accepted; any write (also to an unused index)
  // restarts the image at its first page.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    cfg_next = cfg;
    unique case (cfg_index)
      pabb_pkg::CFG_ORIGIN_X:     cfg_next.origin_x     = cfg_data[6:0];
      pabb_pkg::CFG_ORIGIN_Y:     cfg_next.origin_y     = cfg_data[5:0];
      pabb_pkg::CFG_WIDTH_PX:     cfg_next.width_px     = cfg_data[7:0];
      pabb_pkg::CFG_HEIGHT_PX:    cfg_next.height_px    = cfg_data[6:0];
      pabb_pkg::CFG_PASS_THROUGH: cfg_next.pass_through = cfg_data[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      cfg <= cfg_next;
    end
  end

  // A beat is taken whenever the item stage is free or drains this cycle.
  // Bytes under invalid geometry are taken and dropped.
  assign in_stall = busy;
  assign take     = in_valid && !in_stall;

  pabb_pos #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (cfg_write),
    .restart_page(pabb_pkg::PAGE_W'(cfg_next.origin_y[5:3])),
    .take        (take),
    .image_byte  (image_byte),
    .item_load   (item_load),
    .item        (item),
    .ram_we      (ram_we),
    .ram_re      (ram_re),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata)
  );

  // Line store: last image byte of each column on the page above.
  pabb_ram #(
    .WIDTH(pabb_pkg::DATA_W),
    .DEPTH(DISPLAY_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  pabb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_load (item_load),
    .item      (item),
    .ram_rdata (ram_rdata),
    .out_stall (out_stall),
    .busy      (busy),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .is_command(is_command),
    .last      (last)
  );

endmodule

// ===== rtl/pabb_checker.sv =====
// Port-level checker for the bitmap blit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pabb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       is_command,
  input logic       last
);

  logic [9:0] out_word;

  assign out_word = {out_byte, is_command, last};

  // stalled beat holds
  `PABB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // commands never flag end of image
  `PABB_ASSERT_NOW(a_cmd_not_last, out_valid && is_command, !last)

  // a taken command beat is always followed by the next beat of the group
  `PABB_ASSERT_NEXT(a_cmd_followed, out_valid && !out_stall && is_command, out_valid)

  // output register empty right after reset
  `PABB_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

endmodule

bind page_aligned_bitmap_blit_top pabb_checker u_checker (.*);

// ===== dv/pabb_blit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the page-aligned bitmap blit: follows register writes and image bytes,
// predicts the display byte stream and compares every output beat.
// Depends on pabb_pkg.
module pabb_blit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pabb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [pabb_pkg::DATA_W-1:0]     image_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [pabb_pkg::DATA_W-1:0]     out_byte,
  input  logic                            is_command,
  input  logic                            last,
  output int                              mismatches,
  output int                              beats_pending
);

  typedef struct packed {
    logic [pabb_pkg::DATA_W-1:0] data;
    logic                        cmd;
    logic                        fin;
  } disp_beat_t;

  pabb_pkg::pabb_cfg_t         geom;
  logic [pabb_pkg::DATA_W-1:0] prev_page_bytes [256];  // last image byte seen per column
  logic [pabb_pkg::PAGE_W-1:0] page_pos;
  logic [7:0]                  col_pos;
  disp_beat_t                  display_q [$];
  int                          err_count;

  function automatic bit geometry_valid();
    return geom.width_px != 0 && geom.height_px != 0 &&
           int'(geom.origin_x) + int'(geom.width_px) <= pabb_pkg::DISPLAY_WIDTH_DEF &&
           int'(geom.origin_y) + int'(geom.height_px) <= pabb_pkg::DISPLAY_HEIGHT_DEF;
  endfunction

  function automatic void queue_beat(input logic [pabb_pkg::DATA_W-1:0] data,
                                     input logic cmd, input logic fin);
    disp_beat_t b;
    b.data = data;
    b.cmd  = cmd;
    b.fin  = fin;
    display_q.push_back(b);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Any write, known index or not, restarts the image; the column memory stays.
  task automatic write_register(input logic [pabb_pkg::CFG_IDX_W-1:0] idx,
                                input logic [pabb_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      pabb_pkg::CFG_ORIGIN_X:     geom.origin_x     = val[6:0];
      pabb_pkg::CFG_ORIGIN_Y:     geom.origin_y     = val[5:0];
      pabb_pkg::CFG_WIDTH_PX:     geom.width_px     = val;
      pabb_pkg::CFG_HEIGHT_PX:    geom.height_px    = val[6:0];
      pabb_pkg::CFG_PASS_THROUGH: geom.pass_through = val[0];
      default: ;
    endcase
    page_pos = pabb_pkg::PAGE_W'(geom.origin_y >> 3);
    col_pos  = '0;
  endtask

  task automatic blit_byte(input logic [pabb_pkg::DATA_W-1:0] pix);
    int                          first_pg, final_pg, ofs, n_pages, rel;
    logic [pabb_pkg::DATA_W-1:0] carry, shifted, px_out;
    if (!geometry_valid()) return;
    first_pg = geom.origin_y >> 3;
    final_pg = (int'(geom.origin_y) + int'(geom.height_px) - 1) >> 3;
    ofs      = geom.origin_y[2:0];
    n_pages  = (int'(geom.height_px) + 7) >> 3;
    if (page_pos < first_pg || page_pos > final_pg || col_pos >= geom.width_px) begin
      page_pos = pabb_pkg::PAGE_W'(first_pg);
      col_pos  = '0;
    end
    if (col_pos == 0) begin
      queue_beat(pabb_pkg::CMD_COL_LO_MASK & pabb_pkg::DATA_W'(geom.origin_x),
                 1'b1, 1'b0);
      queue_beat(pabb_pkg::CMD_COL_HI_BASE + pabb_pkg::DATA_W'(geom.origin_x >> 4),
                 1'b1, 1'b0);
      queue_beat(pabb_pkg::CMD_PAGE_BASE + pabb_pkg::DATA_W'(page_pos), 1'b1, 1'b0);
    end
    carry   = (ofs != 0)
            ? pabb_pkg::DATA_W'(prev_page_bytes[col_pos] >> (pabb_pkg::BITS_PER_PAGE - ofs))
            : '0;
    shifted = pabb_pkg::DATA_W'(pix << ofs);
    rel     = int'(page_pos) - first_pg;
    if (rel == 0) begin
      px_out = shifted;
      prev_page_bytes[col_pos] = pix;
    end else if (rel >= n_pages) begin
      px_out = carry;  // spill page: input byte ignored
    end else begin
      px_out = carry | shifted;
      prev_page_bytes[col_pos] = pix;
    end
    if (!geom.pass_through) px_out = ~px_out;
    queue_beat(px_out, 1'b0, page_pos == final_pg && col_pos == geom.width_px - 1);
    col_pos++;
    if (col_pos >= geom.width_px) begin
      col_pos = '0;
      page_pos++;
      if (page_pos > final_pg) page_pos = pabb_pkg::PAGE_W'(first_pg);
    end
  endtask

  always @(posedge clk) begin : track
    disp_beat_t want;
    if (rst) begin
      geom     = '0;
      page_pos = '0;
      col_pos  = '0;
      display_q.delete();
      foreach (prev_page_bytes[i]) prev_page_bytes[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) blit_byte(image_byte);
      if (out_valid && !out_stall) begin
        if (display_q.size() == 0) begin
          report_mismatch("display beat with none pending", out_byte, 0);
        end else begin
          want = display_q.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
          if (is_command !== want.cmd) report_mismatch("is_command", is_command, want.cmd);
          if (last !== want.fin) report_mismatch("last", last, want.fin);
        end
      end
    end
    beats_pending <= display_q.size();
    mismatches    <= err_count;
  end

endmodule

// ===== dv/page_aligned_bitmap_blit_top_tb.sv =====
`timescale 1ns / 100ps
// Top of the bitmap blit testbench: clock, reset, register writes, image byte
// stimulus, output stall patterns and the verdict.
// Depends on pabb_pkg, page_aligned_bitmap_blit_top and pabb_blit_checker.
module page_aligned_bitmap_blit_top_tb;

  localparam int QUIET_LIMIT   = 3000;  // cycles with no beat on any channel
  localparam int SETTLE_CYCLES = 8;     // margin beyond the input-to-output latency
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int RANDOM_ITEMS  = 80;

  // Indexes past the register list; a write there only restarts the image.
  localparam logic [pabb_pkg::CFG_IDX_W-1:0] CFG_FIRST_SPARE =
    pabb_pkg::CFG_PASS_THROUGH + 3'd1;
  localparam logic [pabb_pkg::CFG_IDX_W-1:0] CFG_LAST_SPARE  = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                            clk        = 1'b0;
  logic                            rst        = 1'b1;
  logic                            cfg_valid  = 1'b0;
  logic [pabb_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [pabb_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  logic [7:0]                      image_byte = '0;
  logic                            out_stall  = 1'b0;
  logic                            cfg_ready, in_stall, out_valid, is_command, last;
  logic [7:0]                      out_byte;

  int mismatches, beats_pending;
  int send_idle_pct = 0;   // used by the stimulus process only
  int stall_pct     = 0;
  int hold_kick     = 0;   // bumped to ask the receiver for one long hold-off
  int quiet_cycles  = 0;
  int random_items  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  page_aligned_bitmap_blit_top uut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .image_byte,
    .out_valid, .out_stall, .out_byte, .is_command, .last
  );

  pabb_blit_checker chk (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .image_byte,
    .out_valid, .out_stall, .out_byte, .is_command, .last,
    .mismatches, .beats_pending
  );

  // Receiver: random stalls at stall_pct, plus a long hold-off on request so
  // the block backs up and stalls its input while the sender keeps offering.
  initial begin : receiver
    int kicks_seen;
    kicks_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_kick != kicks_seen) begin
        kicks_seen = hold_kick;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: a run that stops moving beats is a failure.
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
      IDLE_SENDER:   begin send_idle_pct = 87; stall_pct <= 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 87; end
      default:       begin send_idle_pct = 10; stall_pct <= 10; end
    endcase
  endtask

  // One image byte beat; valid stays high into the next beat unless a gap
  // is rolled, so back-to-back beats never drop valid.
  task automatic send_beat(input logic [7:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    image_byte <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random bytes, weighted toward all-zero and all-one columns.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixels(input int n);
    repeat (n) send_beat(pick_pixel());
  endtask

  // Wait until every predicted beat has come out, then give the block a few
  // more cycles: bytes dropped under bad geometry leave nothing to wait on.
  task automatic drain_display();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pabb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pabb_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all five registers; bits above each register's width are random
  // and must be ignored. Sometimes a spare index is hit as well.
  task automatic set_geometry(input int ox, oy, w, h, input bit pt);
    write_reg(pabb_pkg::CFG_ORIGIN_X,     {1'($urandom), 7'(ox)});
    write_reg(pabb_pkg::CFG_ORIGIN_Y,     {2'($urandom), 6'(oy)});
    write_reg(pabb_pkg::CFG_WIDTH_PX,     8'(w));
    write_reg(pabb_pkg::CFG_HEIGHT_PX,    {1'($urandom), 7'(h)});
    write_reg(pabb_pkg::CFG_PASS_THROUGH, {7'($urandom), pt});
    if ($urandom_range(3) == 0)
      write_reg(pabb_pkg::CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)),
                8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int         phase, ox, oy, w, h, beats_per_image, n_images, extra;
    bit         pt, bad;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    set_idling(IDLE_NONE);
    // Registers still zero after reset: zero size, bytes dropped.
    send_beat(8'hFF);
    send_beat(8'h00);
    drain_display();

    // Bottom-right single pixel: one column, one page, offset 7, pass-through.
    // Each byte is a whole image, so the position wraps every beat.
    set_geometry(127, 63, 1, 1, 1'b1);
    send_beat(8'hFF);
    send_beat(8'h00);
    drain_display();

    // Offset 5, eight rows: spills into a tail page built from the carry
    // alone; the two tail bytes are ignored. Output inverted.
    set_geometry(0, 5, 2, 8, 1'b0);
    send_beat(8'hA5);
    send_beat(8'h5A);
    send_beat(8'hFF);
    send_beat(8'h00);
    drain_display();

    // Offset 3 over two image pages (carry merged on the second), broken
    // off after one byte by a write to a spare index, then sent whole.
    set_geometry(60, 3, 2, 12, 1'b1);
    send_beat(8'hC3);
    drain_display();
    write_reg(CFG_LAST_SPARE, 8'hFF);
    cfg_valid <= 1'b0;
    send_pixels(4);
    drain_display();

    // Full-height column, zero row offset: eight pages, no carry.
    set_geometry(0, 0, 1, 64, 1'b0);
    send_pixels(8);
    drain_display();

    // ---- back-pressure: full-width page while the receiver holds off ----
    set_geometry(0, 56, 128, 8, 1'($urandom));
    hold_kick <= hold_kick + 1;
    send_pixels(128);
    drain_display();

    // ---- random phases: mostly whole images, now and then a bad geometry
    // or an image cut short; every idling mode gets at least one phase ----
    phase = 0;
    while (random_items < RANDOM_ITEMS || phase < 4) begin
      set_idling(idle_mode_t'(phase % 4));
      pt  = 1'($urandom);
      bad = 1'b0;
      w   = $urandom_range(1, 6);
      h   = $urandom_range(1, 24);
      oy  = $urandom_range(0, 64 - h);
      ox  = $urandom_range(0, 128 - w);
      case ($urandom_range(9))
        0: begin
          bad = 1'b1;
          case ($urandom_range(3))
            0: w = 0;
            1: h = 0;
            2: begin
              ox = $urandom_range(1, 127);
              w  = $urandom_range(129 - ox, 255);
            end
            default: begin
              oy = $urandom_range(1, 63);
              h  = $urandom_range(65 - oy, 127);
            end
          endcase
        end
        1: begin
          // tall and narrow, down to the bottom row
          w  = $urandom_range(1, 2);
          oy = $urandom_range(0, 7);
          h  = 64 - oy;
          ox = $urandom_range(0, 128 - w);
        end
        default: ;
      endcase
      set_geometry(ox, oy, w, h, pt);
      if (bad) begin
        send_pixels(4);
      end else begin
        beats_per_image = w * (((oy + h - 1) >> 3) - (oy >> 3) + 1);
        n_images = (20 + beats_per_image - 1) / beats_per_image;
        // a partial image left behind is restarted by the next write
        extra = ($urandom_range(3) == 0) ? $urandom_range(beats_per_image - 1) : 0;
        send_pixels(n_images * beats_per_image + extra);
        random_items += n_images * beats_per_image + extra;
      end
      drain_display();
      phase++;
    end

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== page_aligned_bitmap_blit_top.f =====
+incdir+rtl
rtl/pabb_pkg.sv
rtl/pabb_ram.sv
rtl/pabb_pos.sv
rtl/pabb_emit.sv
rtl/page_aligned_bitmap_blit_top.sv
rtl/pabb_checker.sv
dv/pabb_blit_checker.sv
dv/page_aligned_bitmap_blit_top_tb.sv
